FILE: rtl/ctscan_pkg.sv
package ctscan_pkg;

    localparam int TOKEN_MAX = 32;
    localparam int LEN_W = $clog2(TOKEN_MAX + 1);
    localparam int IDX_W = $clog2(TOKEN_MAX);
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef enum logic [3:0] {
        M_NORMAL, M_HASH, M_DIRWORD, M_INC_SEEK, M_INC_FIRST, M_INC_NAME,
        M_SKIP_LINE, M_IDENT, M_NUMBER, M_STRING, M_CHARCONST, M_SLASH,
        M_COMMENT, M_COMMENT_STAR
    } t_mode;

    typedef enum logic [1:0] {
        K_IDENT  = 2'd0,
        K_NUMBER = 2'd1,
        K_STRING = 2'd2,
        K_END    = 2'd3
    } t_kind;

    localparam logic [1:0] CFG_STRIP = 2'd0;
    localparam logic [1:0] CFG_KEEP_LO = 2'd1;
    localparam logic [1:0] CFG_KEEP_HI = 2'd2;

    // one emit command from the front to the back
    typedef struct packed {
        logic [LEN_W-1:0] first;
        logic [LEN_W-1:0] len;
        logic             ovf;
        t_kind            kind;
        logic             eof;
    } t_cmd;

    function automatic logic is_lead(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_num_extra(input logic [7:0] c);
        return (c >= "a" && c <= "f") || (c >= "A" && c <= "F") ||
               c == "x" || c == "X" || c == "l" || c == "L";
    endfunction

    function automatic logic is_boring(input logic [7:0] c);
        return !(c == 8'h0a || is_lead(c) || is_digit(c) || c == 8'h27 ||
                 c == 8'h22 || c == "/");
    endfunction

endpackage

FILE: rtl/ctscan_front.sv
module ctscan_front
    import ctscan_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [7:0]           i_byte_in,
    input  logic                 i_end_of_file,
    input  logic                 i_strip_underscore,
    input  logic [127:0]         i_keep,
    input  logic                 i_busy,
    output logic                 o_ready,
    output logic                 o_cmd_valid,
    output t_cmd                 o_cmd,
    output logic                 o_wr_en,
    output logic [IDX_W-1:0]     o_wr_addr,
    output logic [7:0]           o_wr_data
);

    t_mode             r_mode, n_mode;
    logic              r_line, n_line;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_ovf, n_ovf;
    logic              r_kept, n_kept;
    logic [7:0]        r_w0, r_w1, r_w2, r_w3, r_w4, r_w5, r_w6;
    logic              r_us;
    logic              r_pend, n_pend;
    t_cmd              r_pcmd, n_pcmd;
    logic              r_dw;
    logic [7:0]        r_dc;

    logic [7:0] c;
    logic       put, clr, keep_c;
    t_cmd       cmd;
    logic       cmd_v;

    assign c = i_byte_in;
    // a trailing end token waits behind a token that eof flushed
    assign o_ready = !i_busy && !r_pend && !r_dw;

    always_comb begin
        keep_c = is_lead(c) || is_digit(c);
        if (c[7] == 1'b0)
            keep_c = keep_c || i_keep[c[6:0]];
    end

    function automatic logic word_is(input logic [LEN_W-1:0] len, input logic ovf,
                                     input logic [55:0] w, input logic [LEN_W-1:0] n,
                                     input logic [55:0] s);
        logic ok;
        ok = !ovf && len == n;
        for (int k = 0; k < 7; k++)
            if (k < n && w[8*k +: 8] != s[8*k +: 8])
                ok = 1'b0;
        return ok;
    endfunction

    logic [55:0] w;
    assign w = {r_w6, r_w5, r_w4, r_w3, r_w2, r_w1, r_w0};

    always_comb begin
        logic norm;
        n_mode = r_mode;
        n_line = r_line;
        n_len = r_len;
        n_ovf = r_ovf;
        n_kept = r_kept;
        n_pend = r_pend;
        n_pcmd = r_pcmd;
        put = 1'b0;
        clr = 1'b0;
        norm = 1'b0;
        cmd = '0;
        cmd_v = 1'b0;
        if (r_pend) begin
            if (!i_busy) begin
                cmd_v = 1'b1;
                cmd = r_pcmd;
                n_pend = 1'b0;
            end
        end else if (i_valid && i_end_of_file) begin
            cmd_v = 1'b1;
            cmd.eof = 1'b1;
            cmd.kind = K_END;
            if (r_mode == M_IDENT || r_mode == M_NUMBER) begin
                cmd.eof = 1'b0;
                cmd.kind = (r_mode == M_IDENT) ? K_IDENT : K_NUMBER;
                cmd.len = r_len;
                cmd.ovf = r_ovf;
                n_pend = 1'b1;
                n_pcmd = '0;
                n_pcmd.eof = 1'b1;
                n_pcmd.kind = K_END;
            end
            n_mode = M_NORMAL;
            n_line = 1'b1;
            n_len = '0;
            n_ovf = 1'b0;
            n_kept = 1'b1;
        end else if (i_valid) begin
            unique case (r_mode)
                M_NORMAL: begin
                    if (r_line) begin
                        n_line = 1'b0;
                        if (c == "#") n_mode = M_HASH;
                        else norm = 1'b1;
                    end else norm = 1'b1;
                end
                M_HASH: begin
                    if (!is_boring(c)) begin
                        if (is_lead(c)) begin
                            clr = 1'b1; put = 1'b1; n_mode = M_DIRWORD;
                        end else norm = 1'b1;
                    end
                end
                M_DIRWORD: begin
                    if (is_lead(c) || is_digit(c)) put = 1'b1;
                    else if (word_is(r_len, r_ovf, w, LEN_W'(7), "edulcni"))
                        n_mode = (c == 8'h22 || c == "<") ? M_INC_FIRST : M_INC_SEEK;
                    else if ((r_len >= LEN_W'(2) && r_w0 == "i" && r_w1 == "f") ||
                             word_is(r_len, r_ovf, w, LEN_W'(6), {8'h0, "enifed"}) ||
                             word_is(r_len, r_ovf, w, LEN_W'(5), {16'h0, "fednu"}))
                        norm = 1'b1;
                    else if (c == 8'h0a) begin
                        n_line = 1'b1; n_mode = M_NORMAL;
                    end else n_mode = M_SKIP_LINE;
                end
                M_INC_SEEK: if (c == 8'h22 || c == "<") n_mode = M_INC_FIRST;
                M_INC_FIRST: begin
                    clr = 1'b1; put = 1'b1; n_mode = M_INC_NAME;
                end
                M_INC_NAME: begin
                    if (c == 8'h22 || c == ">") begin
                        cmd_v = r_len != '0;
                        cmd.kind = K_STRING;
                        cmd.len = r_len;
                        cmd.ovf = r_ovf;
                        n_mode = M_NORMAL;
                    end else put = 1'b1;
                end
                M_SKIP_LINE: if (c == 8'h0a) begin
                    n_line = 1'b1; n_mode = M_NORMAL;
                end
                M_IDENT, M_NUMBER: begin
                    if (is_lead(c) && r_mode == M_IDENT || is_digit(c) ||
                        (r_mode == M_NUMBER && is_num_extra(c))) put = 1'b1;
                    else begin
                        cmd_v = 1'b1;
                        cmd.kind = (r_mode == M_IDENT) ? K_IDENT : K_NUMBER;
                        cmd.len = r_len;
                        cmd.ovf = r_ovf;
                        norm = 1'b1;
                    end
                end
                M_STRING: begin
                    if (c == 8'h22) begin
                        if (r_len != '0 && r_kept) begin
                            cmd_v = 1'b1;
                            cmd.kind = K_STRING;
                            cmd.len = r_len;
                            cmd.ovf = r_ovf;
                            if (i_strip_underscore && r_us && r_len > LEN_W'(1))
                                cmd.first = LEN_W'(1);
                        end
                        n_mode = M_NORMAL;
                    end else if (c == 8'h0a) norm = 1'b1;
                    else begin
                        if (!keep_c) n_kept = 1'b0;
                        put = 1'b1;
                    end
                end
                M_CHARCONST: begin
                    if (c == 8'h27) n_mode = M_NORMAL;
                    else if (c == 8'h0a) norm = 1'b1;
                end
                M_SLASH: begin
                    if (c == "*") n_mode = M_COMMENT;
                    else norm = 1'b1;
                end
                M_COMMENT: if (c == "*") n_mode = M_COMMENT_STAR;
                M_COMMENT_STAR: begin
                    if (c == "/") n_mode = M_NORMAL;
                    else if (c != "*") n_mode = M_COMMENT;
                end
                default: norm = 1'b1;
            endcase
            if (norm) begin
                n_mode = M_NORMAL;
                if (c == 8'h22) begin
                    clr = 1'b1; n_mode = M_STRING;
                end else if (c == 8'h27) n_mode = M_CHARCONST;
                else if (c == "/") n_mode = M_SLASH;
                else if (c == 8'h0a) n_line = 1'b1;
                else if (is_lead(c)) begin
                    clr = 1'b1; put = 1'b1; n_mode = M_IDENT;
                end else if (is_digit(c)) begin
                    clr = 1'b1; put = 1'b1; n_mode = M_NUMBER;
                end
            end
            if (clr) begin
                n_len = '0; n_ovf = 1'b0; n_kept = 1'b1;
            end
            if (put) begin
                if ((clr ? '0 : r_len) < LEN_W'(TOKEN_MAX))
                    n_len = (clr ? '0 : r_len) + LEN_W'(1);
                else n_ovf = 1'b1;
            end
        end
    end

    logic [LEN_W-1:0] wpos;
    logic             wr_now;
    assign wpos = clr ? '0 : r_len;
    // a letter that ends a number starts an identifier while the back still needs
    // entry 0, so its write waits until the back is idle
    assign wr_now = put && !cmd_v && wpos < LEN_W'(TOKEN_MAX);
    assign o_wr_en = wr_now || (r_dw && !i_busy);
    assign o_wr_addr = r_dw ? '0 : wpos[IDX_W-1:0];
    assign o_wr_data = r_dw ? r_dc : c;
    assign o_cmd_valid = cmd_v;
    assign o_cmd = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_NORMAL;
            r_line <= 1'b1;
            r_len <= '0;
            r_ovf <= 1'b0;
            r_kept <= 1'b1;
            r_pend <= 1'b0;
        end else if (o_ready || r_pend) begin
            r_mode <= n_mode;
            r_line <= n_line;
            r_len <= n_len;
            r_ovf <= n_ovf;
            r_kept <= n_kept;
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dw <= 1'b0;
        end else if (r_dw) begin
            if (!i_busy) r_dw <= 1'b0;
        end else if (put && cmd_v) begin
            r_dw <= 1'b1;
        end
    end

    // shadow of the first seven characters for directive matching
    always_ff @(posedge i_clk) begin
        r_pcmd <= n_pcmd;
        if (put && cmd_v) r_dc <= c;
        if (wr_now) begin
            unique case (wpos)
                LEN_W'(0): begin r_w0 <= c; r_us <= (c == "_"); end
                LEN_W'(1): r_w1 <= c;
                LEN_W'(2): r_w2 <= c;
                LEN_W'(3): r_w3 <= c;
                LEN_W'(4): r_w4 <= c;
                LEN_W'(5): r_w5 <= c;
                LEN_W'(6): r_w6 <= c;
                default: ;
            endcase
        end
    end

endmodule

FILE: rtl/ctscan_back.sv
module ctscan_back
    import ctscan_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    input  logic              i_wr_en,
    input  logic [IDX_W-1:0]  i_wr_addr,
    input  logic [7:0]        i_wr_data,
    input  logic              i_pop,
    output logic              o_busy,
    output logic              o_empty,
    output logic [7:0]        o_token_char,
    output logic [1:0]        o_token_kind,
    output logic              o_truncated,
    output logic              o_last
);

    logic [7:0]        r_mem [TOKEN_MAX];
    logic              r_act;
    t_cmd              r_cmd;
    logic [LEN_W-1:0]  r_pos;
    logic              r_rv;
    logic [7:0]        r_rd;
    logic [1:0]        r_rk;
    logic              r_rt, r_rl;

    typedef struct packed {
        logic [7:0] ch;
        logic [1:0] kind;
        logic       trunc;
        logic       last;
    } t_res;

    t_res              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_cnt;

    logic step, push_q, pop_q, room;
    logic [QPTR_W:0] inflight;

    assign inflight = r_cnt + {{QPTR_W{1'b0}}, r_rv};
    assign room = inflight < (QPTR_W+1)'(QDEPTH - 1) ||
                  (inflight < (QPTR_W+1)'(QDEPTH) && pop_q);
    assign step = r_act && room;
    assign o_busy = r_act || i_cmd_valid && 1'b0;
    assign pop_q = i_pop && !o_empty;
    assign push_q = r_rv;
    assign o_empty = r_cnt == '0;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_mem[i_wr_addr] <= i_wr_data;
        if (step) r_rd <= r_mem[r_pos[IDX_W-1:0]];
        r_rk <= r_cmd.kind;
        r_rt <= r_cmd.ovf;
        r_rl <= r_cmd.eof || (r_pos + LEN_W'(1) == r_cmd.len);
        if (push_q) r_q[r_wp] <= '{ch: r_rd, kind: r_rk, trunc: r_rt, last: r_rl};
        if (i_cmd_valid) r_cmd <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_pos <= '0;
            r_rv <= 1'b0;
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            r_rv <= step;
            if (i_cmd_valid) begin
                r_act <= 1'b1;
                r_pos <= i_cmd.first;
            end else if (step) begin
                if (r_cmd.eof || r_pos + LEN_W'(1) >= r_cmd.len) r_act <= 1'b0;
                r_pos <= r_pos + LEN_W'(1);
            end
            if (push_q) r_wp <= r_wp + QPTR_W'(1);
            if (pop_q) r_rp <= r_rp + QPTR_W'(1);
            r_cnt <= r_cnt + (QPTR_W+1)'(push_q) - (QPTR_W+1)'(pop_q);
        end
    end

    t_res head;
    assign head = r_q[r_rp];
    assign o_token_char = head.kind == K_END ? 8'h00 : head.ch;
    assign o_token_kind = head.kind;
    assign o_truncated = head.trunc;
    assign o_last = head.last;

endmodule

FILE: rtl/c_source_token_scanner.sv
// result path: the command for the byte ending a token is registered in the back,
// each character is read from the store into a read register, then queued for the result ports
// throughput: one byte per cycle while no token drains; while a token drains (single store
// read port) the input is held, and also while a letter that ends a number waits to be written
// reset: synchronous active-low i_rst_n returns scan state, queue and registers
// to their defaults (strip_underscore 1, keep masks 0); no clearing pass
module c_source_token_scanner
    import ctscan_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_byte_in,
    input  logic        i_end_of_file,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_token_char,
    output logic [1:0]  o_token_kind,
    output logic        o_truncated,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    logic         r_strip;
    logic [127:0] r_keep;
    logic         ready, busy, cmd_v, wr_en;
    t_cmd         cmd;
    logic [IDX_W-1:0] wr_addr;
    logic [7:0]   wr_data;

    assign o_cfg_ready = 1'b1;
    assign full = !ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip <= 1'b1;
            r_keep <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_STRIP:   r_strip <= i_cfg_data[0];
                CFG_KEEP_LO: r_keep[63:0] <= i_cfg_data;
                CFG_KEEP_HI: r_keep[127:64] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ctscan_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(push && ready),
        .i_byte_in, .i_end_of_file,
        .i_strip_underscore(r_strip),
        .i_keep(r_keep),
        .i_busy(busy),
        .o_ready(ready),
        .o_cmd_valid(cmd_v),
        .o_cmd(cmd),
        .o_wr_en(wr_en),
        .o_wr_addr(wr_addr),
        .o_wr_data(wr_data)
    );

    ctscan_back u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(cmd_v),
        .i_cmd(cmd),
        .i_wr_en(wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_pop(pop),
        .o_busy(busy),
        .o_empty(empty),
        .o_token_char,
        .o_token_kind,
        .o_truncated,
        .o_last
    );

endmodule
